// File: design/wcbb_pkg.sv
// Package with the state type and constants of the warped corner bounding box.
`default_nettype none
package wcbb_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W,
    ST_NX,
    ST_NY,
    ST_DIVX,
    ST_DIVY,
    ST_UPD,
    ST_SIZE,
    ST_OUT
  } wcbb_state_t;

  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned OUT_BITS = 24;

  typedef struct packed {
    logic start;
    logic busy;
  } wcbb_div_ctl_t;

endpackage
`default_nettype wire

// File: design/warped_corner_bounding_box.sv
// Top level of the warped corner bounding box: sequencer, box registers, result stage.
//
//  channel | direction | transaction contents
//  in_     | slave     | tdata: h00..h22 (COEFF_WIDTH each); tuser: last_matrix
//  out_    | master    | tdata: origin_x, origin_y, out_width, out_height; tuser: at_infinity
//  cfg_    | write     | index 0 frame_width, index 1 frame_height
//
// One transaction takes 4 corners, each with a multiply-accumulate step for w, x and y, two
// passes through the shared bit-serial divider of NUM+FRAC quotient bits with a hand-off step
// after each, and an update step; the matrix is first accepted in the idle state.
// A corner with w equal to zero skips the divider. A last matrix adds the size and result
// steps. The divider sets the rate.
// Reset is synchronous and active low; it clears the box and loads the reset sizes.
// The input is not ready while a matrix is processed; a last matrix waits in its size step
// until the previous result has been taken on out_tready.
`default_nettype none
module warped_corner_bounding_box #(
  parameter int COEFF_WIDTH = 48,
  parameter int FRAC_BITS   = 24,
  parameter int SIZE_ALIGN  = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [9*COEFF_WIDTH-1:0]   in_tdata,   // h00,h01,h02,h10,h11,h12,h20,h21,h22
  input  wire                        in_tuser,   // last_matrix
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [95:0]                out_tdata,  // origin_x,origin_y,out_width,out_height
  output logic                       out_tuser,  // at_infinity
  input  wire                        cfg_we,
  input  wire  [0:0]                 cfg_index,
  input  wire  [15:0]                cfg_data
);
  // A sum of three coefficient*16-bit products needs COEFF_WIDTH+18 bits.
  localparam int NUM_WIDTH = COEFF_WIDTH + 18;
  localparam int OB = wcbb_pkg::OUT_BITS;
  localparam logic [OB-1:0] LIMIT = OB'(((2**OB - 1) / SIZE_ALIGN) * SIZE_ALIGN);
  // Rounding up to the alignment uses a reciprocal multiplication that is exact for
  // every value below 2^(OB+1).
  localparam int AL_BITS = $clog2(SIZE_ALIGN);
  localparam int RS = OB + 1 + AL_BITS;
  localparam int RM_BITS = OB + 3;
  localparam logic [RM_BITS-1:0] RM =
    RM_BITS'(((64'd1 << RS) + 64'(SIZE_ALIGN) - 64'd1) / 64'(SIZE_ALIGN));
  localparam int PW = OB + 1 + RM_BITS;

  wcbb_pkg::wcbb_state_t state_r, state_nxt;

  logic [15:0] fw_r, fh_r;
  logic [9*COEFF_WIDTH-1:0] h_r;
  logic last_r;
  logic [1:0] corner_r, corner_nxt;
  logic signed [NUM_WIDTH-1:0] w_r, w_nxt, nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [COEFF_WIDTH-1:0] px_r, px_nxt;
  logic signed [COEFF_WIDTH-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic signed [COEFF_WIDTH-1:0] minx_nxt, maxx_nxt, miny_nxt, maxy_nxt;
  logic empty_r, empty_nxt, inf_r, inf_nxt;
  logic [OB-1:0] csx_r, csx_nxt, csy_r, csy_nxt;
  logic [95:0] od_r, od_nxt;
  logic ou_r, ou_nxt, ov_r, ov_nxt;
  logic div_start;
  logic signed [NUM_WIDTH-1:0] div_num;
  wcbb_pkg::wcbb_div_ctl_t div_ctl;
  logic signed [COEFF_WIDTH-1:0] div_q;

  // Shared multiply-accumulate: row dot (x, y, 1) for one matrix row per cycle.
  logic [1:0] row;
  logic signed [COEFF_WIDTH-1:0] c0, c1, c2;
  logic signed [16:0] xs, ys;
  logic signed [NUM_WIDTH-1:0] dot;

  always_comb begin
    case (state_r)
      wcbb_pkg::ST_NX: row = 2'd0;
      wcbb_pkg::ST_NY: row = 2'd1;
      default:         row = 2'd2;
    endcase
  end
  assign c0 = h_r[(3*row)*COEFF_WIDTH +: COEFF_WIDTH];
  assign c1 = h_r[(3*row+1)*COEFF_WIDTH +: COEFF_WIDTH];
  assign c2 = h_r[(3*row+2)*COEFF_WIDTH +: COEFF_WIDTH];
  assign xs = corner_r[0] ? {1'b0, fw_r} : 17'sd0;
  assign ys = corner_r[1] ? {1'b0, fh_r} : 17'sd0;
  assign dot = NUM_WIDTH'(c0 * xs) + NUM_WIDTH'(c1 * ys) + NUM_WIDTH'(c2);

  // The x numerator is ready when the first division starts; the y numerator after it.
  assign div_num = (state_r == wcbb_pkg::ST_NY) ? nx_r : ny_r;

  wcbb_div #(
    .COEFF_WIDTH(COEFF_WIDTH), .FRAC_BITS(FRAC_BITS), .NUM_WIDTH(NUM_WIDTH)
  ) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(w_r),
    .ctl(div_ctl), .quo(div_q)
  );

  function automatic logic [OB-1:0] floor_sat(input logic signed [COEFF_WIDTH-1:0] v);
    logic signed [COEFF_WIDTH-1:0] f;
    f = v >>> FRAC_BITS;
    if (f > COEFF_WIDTH'(2**(OB-1) - 1)) return {1'b0, {(OB-1){1'b1}}};
    if (f < -COEFF_WIDTH'(2**(OB-1))) return {1'b1, {(OB-1){1'b0}}};
    return OB'(f);
  endfunction

  // Ceiling of the box extent in whole pixels, clamped to the largest aligned size.
  function automatic logic [OB-1:0] ceil_size(input logic signed [COEFF_WIDTH-1:0] lo,
                                              input logic signed [COEFF_WIDTH-1:0] hi);
    logic [COEFF_WIDTH-1:0] d;
    logic [COEFF_WIDTH:0] c;
    d = COEFF_WIDTH'(hi - lo);
    c = (COEFF_WIDTH+1)'(d >> FRAC_BITS) +
        ((d[FRAC_BITS-1:0] != '0) ? (COEFF_WIDTH+1)'(1) : (COEFF_WIDTH+1)'(0));
    if (c > (COEFF_WIDTH+1)'(LIMIT)) return LIMIT;
    return OB'(c);
  endfunction

  // Rounds a clamped size up to the next multiple of SIZE_ALIGN.
  function automatic logic [OB-1:0] align_size(input logic [OB-1:0] c);
    logic [OB:0] cp;
    logic [PW-1:0] p;
    cp = (OB+1)'(c) + (OB+1)'(SIZE_ALIGN - 1);
    p = PW'(cp) * PW'(RM);
    return OB'((p >> RS) * PW'(SIZE_ALIGN));
  endfunction

  always_comb begin
    state_nxt = state_r; corner_nxt = corner_r;
    w_nxt = w_r; nx_nxt = nx_r; ny_nxt = ny_r; px_nxt = px_r;
    minx_nxt = minx_r; maxx_nxt = maxx_r; miny_nxt = miny_r; maxy_nxt = maxy_r;
    empty_nxt = empty_r; inf_nxt = inf_r;
    csx_nxt = csx_r; csy_nxt = csy_r;
    od_nxt = od_r; ou_nxt = ou_r; ov_nxt = ov_r;
    div_start = 1'b0;
    in_tready = (state_r == wcbb_pkg::ST_IDLE);
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      wcbb_pkg::ST_IDLE: begin
        corner_nxt = 2'd0;
        if (in_tvalid) state_nxt = wcbb_pkg::ST_W;
      end
      wcbb_pkg::ST_W: begin
        w_nxt = dot;
        state_nxt = wcbb_pkg::ST_NX;
      end
      wcbb_pkg::ST_NX: begin
        if (w_r == '0) begin
          inf_nxt = 1'b1;
          state_nxt = wcbb_pkg::ST_UPD;
        end else begin
          nx_nxt = dot;
          state_nxt = wcbb_pkg::ST_NY;
        end
      end
      wcbb_pkg::ST_NY: begin
        ny_nxt = dot;
        div_start = 1'b1;
        state_nxt = wcbb_pkg::ST_DIVX;
      end
      wcbb_pkg::ST_DIVX: begin
        if (!div_ctl.busy) begin
          px_nxt = div_q;
          div_start = 1'b1;
          state_nxt = wcbb_pkg::ST_DIVY;
        end
      end
      wcbb_pkg::ST_DIVY: begin
        if (!div_ctl.busy) begin
          if (empty_r) begin
            minx_nxt = px_r; maxx_nxt = px_r; miny_nxt = div_q; maxy_nxt = div_q;
            empty_nxt = 1'b0;
          end else begin
            if (px_r < minx_r) minx_nxt = px_r;
            if (px_r > maxx_r) maxx_nxt = px_r;
            if (div_q < miny_r) miny_nxt = div_q;
            if (div_q > maxy_r) maxy_nxt = div_q;
          end
          state_nxt = wcbb_pkg::ST_UPD;
        end
      end
      wcbb_pkg::ST_UPD: begin
        corner_nxt = corner_r + 2'd1;
        if (corner_r != 2'd3) state_nxt = wcbb_pkg::ST_W;
        else if (last_r) state_nxt = wcbb_pkg::ST_SIZE;
        else state_nxt = wcbb_pkg::ST_IDLE;
      end
      wcbb_pkg::ST_SIZE: begin
        // The previous result must be gone before this one is built.
        if (!ov_r) begin
          csx_nxt = ceil_size(minx_r, maxx_r);
          csy_nxt = ceil_size(miny_r, maxy_r);
          state_nxt = wcbb_pkg::ST_OUT;
        end
      end
      wcbb_pkg::ST_OUT: begin
        if (empty_r) od_nxt = '0;
        else od_nxt = {align_size(csy_r), align_size(csx_r),
                       floor_sat(miny_r), floor_sat(minx_r)};
        ou_nxt = inf_r;
        ov_nxt = 1'b1;
        minx_nxt = '0; maxx_nxt = '0; miny_nxt = '0; maxy_nxt = '0;
        empty_nxt = 1'b1; inf_nxt = 1'b0;
        state_nxt = wcbb_pkg::ST_IDLE;
      end
      default: state_nxt = wcbb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcbb_pkg::ST_IDLE;
      fw_r <= 16'd640; fh_r <= 16'd480;
      minx_r <= '0; maxx_r <= '0; miny_r <= '0; maxy_r <= '0;
      empty_r <= 1'b1; inf_r <= 1'b0; ov_r <= 1'b0; corner_r <= 2'd0;
    end else begin
      state_r <= state_nxt; corner_r <= corner_nxt;
      minx_r <= minx_nxt; maxx_r <= maxx_nxt; miny_r <= miny_nxt; maxy_r <= maxy_nxt;
      empty_r <= empty_nxt; inf_r <= inf_nxt; ov_r <= ov_nxt;
      if (cfg_we) begin
        if (cfg_index == wcbb_pkg::CFG_FRAME_WIDTH) fw_r <= cfg_data;
        else fh_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt; nx_r <= nx_nxt; ny_r <= ny_nxt; px_r <= px_nxt;
    csx_r <= csx_nxt; csy_r <= csy_nxt;
    od_r <= od_nxt; ou_r <= ou_nxt;
    if (in_tvalid && in_tready) begin
      h_r <= in_tdata;
      last_r <= in_tuser;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  // An empty box has its bounds at zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (minx_r == '0 && maxx_r == '0)) else $error("empty box not cleared");
  // Once filled, the box is ordered.
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> (minx_r <= maxx_r && miny_r <= maxy_r)) else $error("box unordered");
  // The divider runs only while the sequencer waits on it.
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.busy |-> (state_r == wcbb_pkg::ST_DIVX || state_r == wcbb_pkg::ST_DIVY))
    else $error("divider busy outside divide states");
  // A division is never started while another one is running.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_ctl.busy) else $error("divider restarted while busy");
endmodule
`default_nettype wire

// File: design/wcbb_div.sv
// Restoring bit-serial divider: floor(num * 2^FRAC / den), saturated to COEFF_WIDTH.
`default_nettype none
module wcbb_div #(
  parameter int COEFF_WIDTH = 48,
  parameter int FRAC_BITS   = 24,
  parameter int NUM_WIDTH   = 70
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire signed [NUM_WIDTH-1:0]     num,
  input  wire signed [NUM_WIDTH-1:0]     den,
  output wcbb_pkg::wcbb_div_ctl_t        ctl,
  output logic signed [COEFF_WIDTH-1:0]  quo
);
  localparam int NW = NUM_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]        n_r, n_nxt;
  logic [NUM_WIDTH:0]   r_r, r_nxt;
  logic [NUM_WIDTH-1:0] d_r, d_nxt;
  logic [NW-1:0]        q_r, q_nxt;
  logic                 neg_r, neg_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [NUM_WIDTH-1:0] nmag, dmag;
  logic [NUM_WIDTH:0]   rsh;
  logic [NW:0]          qf;
  logic [NW:0]          half;

  assign nmag = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
  assign dmag = den[NUM_WIDTH-1] ? NUM_WIDTH'(-den) : NUM_WIDTH'(den);
  assign rsh  = {r_r[NUM_WIDTH-1:0], n_r[NW-1]};

  always_comb begin
    n_nxt = n_r; r_nxt = r_r; d_nxt = d_r; q_nxt = q_r;
    neg_nxt = neg_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    if (start) begin
      n_nxt    = {nmag, {FRAC_BITS{1'b0}}};
      d_nxt    = dmag;
      r_nxt    = '0;
      q_nxt    = '0;
      neg_nxt  = num[NUM_WIDTH-1] ^ den[NUM_WIDTH-1];
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[NW-2:0], 1'b0};
      if (rsh >= {1'b0, d_r}) begin
        r_nxt = rsh - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        r_nxt = rsh;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; r_r <= r_nxt; d_r <= d_nxt; q_r <= q_nxt;
    neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  // Final rounding toward minus infinity and saturation.
  assign half = (NW+1)'(1) << (COEFF_WIDTH - 1);
  always_comb begin
    qf = {1'b0, q_r} + ((neg_r && (r_r != '0)) ? (NW+1)'(1) : (NW+1)'(0));
    if (neg_r) begin
      if (qf > half) quo = {1'b1, {(COEFF_WIDTH-1){1'b0}}};
      else quo = COEFF_WIDTH'(-qf);
    end else begin
      if (qf > half - 1'b1) quo = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
      else quo = COEFF_WIDTH'(qf);
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the warped corner bounding box.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int CW = 48;
  localparam int FB = 24;
  localparam int ALIGN = 16;
  localparam int DRAIN_CYCLES = 1000;
  localparam longint CYCLE_LIMIT = 10000000;

  // One set of box results as it leaves the block.
  typedef struct packed {
    logic [23:0] origin_x;
    logic [23:0] origin_y;
    logic [23:0] box_w;
    logic [23:0] box_h;
    logic        at_inf;
  } box_result_t;

  typedef logic signed [CW-1:0] coeff_t;
  typedef coeff_t matrix_t [9];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [9*CW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = wcbb_pkg::CFG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;

  // Predictor state: frame size registers and the running box.
  logic [15:0] frame_w = 16'd640;
  logic [15:0] frame_h = 16'd480;
  logic signed [CW-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic box_is_empty = 1'b1;
  logic inf_seen = 1'b0;

  box_result_t expected_boxes[$];
  int errors = 0;
  longint cycle_count = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_off_cycles = 0;

  warped_corner_bounding_box dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Global watchdog; a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Floor of num * 2^FB / den, saturated to the coefficient range. The 128-bit
  // signed arithmetic here is exact for all 48-bit coefficients and 16-bit sizes.
  function automatic logic signed [CW-1:0] floor_quot(logic signed [127:0] num,
                                                      logic signed [127:0] den);
    logic signed [127:0] n, q, r;
    logic signed [127:0] hi_lim, lo_lim;
    n = num <<< FB;
    q = n / den;
    r = n % den;
    // SystemVerilog division truncates; step down when the signs differ.
    if (r != 0 && ((r < 0) != (den < 0))) q = q - 1;
    hi_lim = (128'sd1 <<< (CW - 1)) - 1;
    lo_lim = -(128'sd1 <<< (CW - 1));
    if (q > hi_lim) q = hi_lim;
    if (q < lo_lim) q = lo_lim;
    return q[CW-1:0];
  endfunction

  function automatic logic [23:0] integer_floor(logic signed [CW-1:0] v);
    logic signed [CW-1:0] f;
    f = v >>> FB;
    if (f > 48'sd8388607) return 24'h7FFFFF;
    if (f < -48'sd8388608) return 24'h800000;
    return f[23:0];
  endfunction

  function automatic logic [23:0] aligned_size(logic signed [CW-1:0] lo_v,
                                               logic signed [CW-1:0] hi_v);
    logic [63:0] d, c, limit;
    d = 64'(hi_v) - 64'(lo_v);
    c = (d >> FB) + ((d[FB-1:0] != 0) ? 64'd1 : 64'd0);
    limit = (64'hFFFFFF / ALIGN) * ALIGN;
    if (c > limit) return limit[23:0];
    c = ((c + ALIGN - 1) / ALIGN) * ALIGN;
    return c[23:0];
  endfunction

  // Maps the four corners through the matrix and grows the box. On the last
  // matrix of a set it queues the expected result and clears the box.
  task automatic predict_box(input matrix_t m, input logic last_m);
    logic signed [127:0] cx, cy, wv, nx, ny;
    logic signed [CW-1:0] px, py;
    box_result_t res;
    for (int c = 0; c < 4; c++) begin
      cx = (c & 1) ? $signed({112'd0, frame_w}) : 128'sd0;
      cy = (c & 2) ? $signed({112'd0, frame_h}) : 128'sd0;
      wv = 128'(m[6]) * cx + 128'(m[7]) * cy + 128'(m[8]);
      if (wv == 0) begin
        // A corner at infinity is flagged and left out of the box.
        inf_seen = 1'b1;
        continue;
      end
      nx = 128'(m[0]) * cx + 128'(m[1]) * cy + 128'(m[2]);
      ny = 128'(m[3]) * cx + 128'(m[4]) * cy + 128'(m[5]);
      px = floor_quot(nx, wv);
      py = floor_quot(ny, wv);
      if (box_is_empty) begin
        box_min_x = px; box_max_x = px; box_min_y = py; box_max_y = py;
        box_is_empty = 1'b0;
      end else begin
        if (px < box_min_x) box_min_x = px;
        if (px > box_max_x) box_max_x = px;
        if (py < box_min_y) box_min_y = py;
        if (py > box_max_y) box_max_y = py;
      end
    end
    if (last_m) begin
      res = '0;
      if (!box_is_empty) begin
        res.origin_x = integer_floor(box_min_x);
        res.origin_y = integer_floor(box_min_y);
        res.box_w = aligned_size(box_min_x, box_max_x);
        res.box_h = aligned_size(box_min_y, box_max_y);
      end
      res.at_inf = inf_seen;
      expected_boxes = {expected_boxes, res};
      box_is_empty = 1'b1;
      inf_seen = 1'b0;
      box_min_x = '0; box_max_x = '0; box_min_y = '0; box_max_y = '0;
    end
  endtask

  // Offers one matrix, with an optional random gap first, and waits for its
  // transaction. Valid stays high across back-to-back matrices.
  task automatic send_matrix(input matrix_t m, input logic last_m);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) in_tdata[i*CW +: CW] <= m[i];
    in_tuser <= last_m;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_box(m, last_m);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected result has come out, plus settling time.
  task automatic wait_idle();
    stop_sending();
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [15:0] w, input logic [15:0] h);
    cfg_we <= 1'b1; cfg_index <= wcbb_pkg::CFG_FRAME_WIDTH; cfg_data <= w;
    @(posedge clk);
    frame_w = w;
    cfg_index <= wcbb_pkg::CFG_FRAME_HEIGHT; cfg_data <= h;
    @(posedge clk);
    frame_h = h;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coeff_t rand_coeff();
    case ($urandom_range(0, 5))
      0: return coeff_t'({$urandom, $urandom});
      1: return coeff_t'($signed($urandom_range(0, 4000)) - 2000);
      2: return 48'sh7FFFFFFFFFFF;
      3: return 48'sh800000000000;
      default: return coeff_t'($signed(32'($urandom) >>> $urandom_range(4, 30)));
    endcase
  endfunction

  // A plausible homography: near identity with small random perturbations.
  function automatic matrix_t realistic_matrix();
    matrix_t m;
    for (int i = 0; i < 9; i++)
      m[i] = coeff_t'($signed(32'($urandom)) >>> $urandom_range(8, 30));
    m[0] = m[0] + (48'sd1 <<< FB);
    m[4] = m[4] + (48'sd1 <<< FB);
    m[8] = m[8] + (48'sd1 <<< FB);
    m[6] = m[6] >>> 12;
    m[7] = m[7] >>> 12;
    return m;
  endfunction

  function automatic matrix_t identity_matrix();
    matrix_t m;
    foreach (m[i]) m[i] = '0;
    m[0] = 48'sd1 <<< FB; m[4] = 48'sd1 <<< FB; m[8] = 48'sd1 <<< FB;
    return m;
  endfunction

  // Directed sets: identity, extremes, corners at infinity, empty box,
  // saturating coordinates and a multi-matrix set.
  task automatic test_directed();
    matrix_t m;
    send_matrix(identity_matrix(), 1'b1);
    m = identity_matrix(); m[2] = -(48'sd5 <<< FB) - 1; m[5] = 48'sd3 <<< (FB - 1);
    send_matrix(m, 1'b1);
    // All w zero: every corner at infinity, so the box stays empty.
    foreach (m[i]) m[i] = 48'sh7FFFFFFFFFFF;
    m[6] = '0; m[7] = '0; m[8] = '0;
    send_matrix(m, 1'b1);
    // The two corners with x at zero go to infinity.
    m = identity_matrix(); m[6] = 48'sd1; m[8] = '0;
    send_matrix(m, 1'b1);
    // Extreme coefficients with a tiny w saturate the coordinates.
    foreach (m[i]) m[i] = 48'sh7FFFFFFFFFFF;
    m[6] = '0; m[7] = '0; m[8] = 48'sd1;
    send_matrix(m, 1'b1);
    foreach (m[i]) m[i] = 48'sh800000000000;
    m[6] = '0; m[7] = '0; m[8] = -48'sd1;
    send_matrix(m, 1'b1);
    foreach (m[i]) m[i] = 48'sh800000000000;
    send_matrix(m, 1'b1);
    foreach (m[i]) m[i] = -48'sd1;
    send_matrix(m, 1'b1);
    // A set of three matrices that closes with one result.
    send_matrix(realistic_matrix(), 1'b0);
    send_matrix(identity_matrix(), 1'b0);
    m = identity_matrix(); m[0] = 48'sd3 <<< FB;
    send_matrix(m, 1'b1);
    wait_idle();
  endtask

  // Frame size extremes, including the zero size that collapses the corners.
  task automatic test_frame_sizes();
    logic [15:0] sizes [5] = '{16'd0, 16'd1, 16'hFFFF, 16'd1920, 16'd7};
    for (int s = 0; s < 5; s++) begin
      write_frame_size(sizes[s], sizes[4 - s]);
      send_matrix(identity_matrix(), 1'b1);
      send_matrix(realistic_matrix(), 1'b0);
      send_matrix(rand_coeff() == 0 ? identity_matrix() : realistic_matrix(), 1'b1);
      wait_idle();
    end
  endtask

  // Random sets, mostly realistic matrices, some fully random noise.
  task automatic test_random(input int count);
    matrix_t m;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        foreach (m[i]) m[i] = rand_coeff();
        if ($urandom_range(0, 5) == 0) m[8] = '0;
      end else begin
        m = realistic_matrix();
      end
      send_matrix(m, $urandom_range(0, 2) == 0);
    end
  endtask

  // The receiver holds off for a long stretch while matrices keep coming.
  task automatic test_back_pressure();
    hold_off_cycles = 3000;
    for (int n = 0; n < 8; n++) send_matrix(realistic_matrix(), 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_frame_sizes();
    write_frame_size($urandom, $urandom);
    test_random(600);
    wait_idle();
    write_frame_size(16'd640, 16'd480);
    test_back_pressure();
    test_random(600);
    wait_idle();
    write_frame_size($urandom_range(1, 200), $urandom_range(1, 200));
    test_random(200);
    // Final stretch without any idling on either side.
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random(250);
    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus the long hold-off when requested.
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Result checker: each accepted transaction is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    box_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[23:0], out_tdata[47:24], out_tdata[71:48], out_tdata[95:72],
             out_tuser};
      if (expected_boxes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $realtime, got);
      end else begin
        want = expected_boxes.pop_front();
        if (got.origin_x !== want.origin_x) begin
          errors++;
          $display("%0t: origin_x expected %h actual %h", $realtime, want.origin_x,
                   got.origin_x);
        end
        if (got.origin_y !== want.origin_y) begin
          errors++;
          $display("%0t: origin_y expected %h actual %h", $realtime, want.origin_y,
                   got.origin_y);
        end
        if (got.box_w !== want.box_w) begin
          errors++;
          $display("%0t: width expected %h actual %h", $realtime, want.box_w, got.box_w);
        end
        if (got.box_h !== want.box_h) begin
          errors++;
          $display("%0t: height expected %h actual %h", $realtime, want.box_h, got.box_h);
        end
        if (got.at_inf !== want.at_inf) begin
          errors++;
          $display("%0t: at_infinity expected %b actual %b", $realtime, want.at_inf,
                   got.at_inf);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: filelist.f
design/wcbb_pkg.sv
design/wcbb_div.sv
design/warped_corner_bounding_box.sv
tb/sv/tb_top.sv
